FILE: hdl/rpay_pkg.sv
// Package for the y-axis point rotator: item types, fixed-point widths,
// CORDIC constants, the arctangent table and the round-and-saturate function.
// No dependencies.
package rpay_pkg;

    // Default number of CORDIC iterations (valid range 8 to 32).
    localparam int CORDIC_STEPS_DEF = 24;

    // Coordinate width, Q16.16.
    localparam int PW  = 32;
    // CORDIC vector width, Q2.30 with headroom.
    localparam int CW  = 33;
    // Residual angle width, Q2.30 with headroom for unfolded input angles.
    localparam int RW  = 34;
    // Width of one arctangent table entry.
    localparam int ATW = 30;
    // Product width of one coordinate and one vector component.
    localparam int MW  = PW + CW;
    // Width of the sum of two products.
    localparam int SW  = MW + 1;
    // Fraction bits dropped when scaling a product back to Q16.16.
    localparam int FRAC = 30;

    // Gain of the infinite iteration, 0.60725293500888 in Q30.
    localparam logic signed [CW-1:0] GAIN_Q30    = 33'sd652032874;
    localparam logic signed [RW-1:0] HALF_PI_Q30 = 34'sd1686629713;
    localparam logic signed [RW-1:0] PI_Q30      = 34'sd3373259426;

    // atan(2^-i) in Q30, i = 0..31.
    localparam logic [ATW-1:0] ATAN_Q30 [32] = '{
        30'h3243F6A8, 30'h1DAC6705, 30'h0FADBAFC, 30'h07F56EA6,
        30'h03FEAB76, 30'h01FFD55B, 30'h00FFFAAA, 30'h007FFF55,
        30'h003FFFEA, 30'h001FFFFD, 30'h000FFFFF, 30'h0007FFFF,
        30'h0003FFFF, 30'h0001FFFF, 30'h0000FFFF, 30'h00007FFF,
        30'h00003FFF, 30'h00001FFF, 30'h00000FFF, 30'h000007FF,
        30'h000003FF, 30'h000001FF, 30'h000000FF, 30'h0000007F,
        30'h0000003F, 30'h0000001F, 30'h0000000F, 30'h00000008,
        30'h00000004, 30'h00000002, 30'h00000001, 30'h00000000
    };

    // Input item: one point and its rotation angle.
    typedef struct packed {
        logic signed [PW-1:0] coord_x;
        logic signed [PW-1:0] coord_z;
        logic signed [PW-1:0] angle;
    } in_item_t;

    // Result item: the rotated coordinates.
    typedef struct packed {
        logic signed [PW-1:0] rot_x;
        logic signed [PW-1:0] rot_z;
    } out_item_t;

    // Data carried along the row of CORDIC cells.
    typedef struct packed {
        logic signed [PW-1:0] px;
        logic signed [PW-1:0] pz;
        logic                 flip;
        logic signed [RW-1:0] res;
        logic signed [CW-1:0] cx;
        logic signed [CW-1:0] sy;
    } cord_t;

    // Point and final cos/sin after the quadrant correction.
    typedef struct packed {
        logic signed [PW-1:0] px;
        logic signed [PW-1:0] pz;
        logic signed [CW-1:0] cx;
        logic signed [CW-1:0] sy;
    } vec_t;

    // The four partial products.
    typedef struct packed {
        logic signed [MW-1:0] p_xc;
        logic signed [MW-1:0] p_zs;
        logic signed [MW-1:0] p_zc;
        logic signed [MW-1:0] p_xs;
    } prod_t;

    // Pipeline control shared by every stage ahead of the output buffer.
    typedef struct packed {
        logic ce;
    } pipe_ctl_t;

    // Round half up at bit FRAC and clamp to the 32-bit signed range.
    function automatic logic signed [PW-1:0] round_sat(input logic signed [SW-1:0] acc);
        logic signed [SW-1:0]      biased;
        logic signed [SW-FRAC-1:0] scaled;
        logic signed [PW-1:0]      result;
        biased = acc + (SW'(1) <<< (FRAC - 1));
        scaled = (SW-FRAC)'(biased >>> FRAC);
        if (scaled > (SW-FRAC)'(36'sh07FFFFFFF)) begin
            result = 32'sh7FFFFFFF;
        end else if (scaled < -(SW-FRAC)'(36'sh080000000)) begin
            result = 32'sh80000000;
        end else begin
            result = scaled[PW-1:0];
        end
        return result;
    endfunction

endpackage

FILE: hdl/rotate_point_about_y_axis.sv
// Top level of the y-axis point rotator: fold stage, a row of CORDIC cells,
// the product stages and the output buffer. Depends on rpay_pkg, rpay_fold, rpay_cell, rpay_mult and rpay_obuf.
//
//  Channel | Ports                        | Direction | Contents
//  --------+------------------------------+-----------+---------------------------------
//  input   | s_valid, s_ready, s_item     | in        | coord_x, coord_z, angle
//  result  | m_valid, m_ready, m_item     | out       | rot_x, rot_z
//
// One item is accepted per cycle while s_ready is high; each result passes through the
// fold stage, one register per CORDIC cell, the correction stage, the product stage
// and the output register.
// Reset clears only the valid bits; there is no clearing pass.
// When a result is stalled the pipeline keeps moving until the next result lands in
// the skid register; s_ready then drops until the output drains.
module rotate_point_about_y_axis
    import rpay_pkg::*;
#(
    parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
)
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  in_item_t  s_item,
    output logic      m_valid,
    input  logic      m_ready,
    output out_item_t m_item
);

    pipe_ctl_t ctl;
    logic      stage_valid [CORDIC_STEPS+1];
    cord_t     stage_data  [CORDIC_STEPS+1];
    logic      prod_valid;
    prod_t     prod_data;

    assign s_ready = ctl.ce;

    // Angle fold and vector load.
    rpay_fold u_fold (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ctl       (ctl),
        .in_valid  (s_valid),
        .in_item   (s_item),
        .out_valid (stage_valid[0]),
        .out_data  (stage_data[0])
    );

    // Row of CORDIC cells, one iteration each.
    for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_cell
        rpay_cell #(
            .SHIFT (i)
        ) u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .ctl       (ctl),
            .in_valid  (stage_valid[i]),
            .in_data   (stage_data[i]),
            .out_valid (stage_valid[i+1]),
            .out_data  (stage_data[i+1])
        );
    end

    // Quadrant correction and products.
    rpay_mult u_mult (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ctl       (ctl),
        .in_valid  (stage_valid[CORDIC_STEPS]),
        .in_data   (stage_data[CORDIC_STEPS]),
        .out_valid (prod_valid),
        .out_data  (prod_data)
    );

    // Rounding, saturation and output buffering.
    rpay_obuf u_obuf (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (prod_valid),
        .in_data  (prod_data),
        .ctl      (ctl),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_item   (m_item)
    );

endmodule

FILE: hdl/rpay_fold.sv
// Entry stage: scales the angle to Q2.30, folds it into minus pi/2 to pi/2
// and loads the starting CORDIC vector. Depends on rpay_pkg.
module rpay_fold
    import rpay_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  pipe_ctl_t ctl,
    input  logic      in_valid,
    input  in_item_t  in_item,
    output logic      out_valid,
    output cord_t     out_data
);

    logic  valid_reg;
    cord_t data_reg;
    cord_t data_next;
    logic signed [RW-1:0] res_raw;

    // Fold the angle once so the iterations only see the right half plane.
    always_comb begin
        res_raw        = {in_item.angle[PW-1], in_item.angle, 1'b0};
        data_next.px   = in_item.coord_x;
        data_next.pz   = in_item.coord_z;
        data_next.cx   = GAIN_Q30;
        data_next.sy   = '0;
        data_next.flip = 1'b0;
        data_next.res  = res_raw;
        if (res_raw > HALF_PI_Q30) begin
            data_next.res  = res_raw - PI_Q30;
            data_next.flip = 1'b1;
        end else if (res_raw < -HALF_PI_Q30) begin
            data_next.res  = res_raw + PI_Q30;
            data_next.flip = 1'b1;
        end
    end

    // Valid bit.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (ctl.ce) begin
            valid_reg <= in_valid;
        end
    end

    // Payload.
    always_ff @(posedge aclk) begin
        if (ctl.ce) begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

FILE: hdl/rpay_cell.sv
// One CORDIC rotation cell: a fixed shift and arctangent step, registered.
// Depends on rpay_pkg.
module rpay_cell
    import rpay_pkg::*;
#(
    parameter int SHIFT = 0
)
(
    input  logic      aclk,
    input  logic      aresetn,
    input  pipe_ctl_t ctl,
    input  logic      in_valid,
    input  cord_t     in_data,
    output logic      out_valid,
    output cord_t     out_data
);

    localparam logic signed [RW-1:0] ATAN_STEP = RW'(ATAN_Q30[SHIFT]);

    logic  valid_reg;
    cord_t data_reg;
    cord_t data_next;
    logic signed [CW-1:0] cx_in;
    logic signed [CW-1:0] sy_in;
    logic signed [CW-1:0] dx;
    logic signed [CW-1:0] dy;

    // Rotate toward zero residual angle.
    always_comb begin
        cx_in     = in_data.cx;
        sy_in     = in_data.sy;
        dx        = sy_in >>> SHIFT;
        dy        = cx_in >>> SHIFT;
        data_next = in_data;
        if (!in_data.res[RW-1]) begin
            data_next.cx  = cx_in - dx;
            data_next.sy  = sy_in + dy;
            data_next.res = in_data.res - ATAN_STEP;
        end else begin
            data_next.cx  = cx_in + dx;
            data_next.sy  = sy_in - dy;
            data_next.res = in_data.res + ATAN_STEP;
        end
    end

    // Valid bit.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (ctl.ce) begin
            valid_reg <= in_valid;
        end
    end

    // Payload.
    always_ff @(posedge aclk) begin
        if (ctl.ce) begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

FILE: hdl/rpay_mult.sv
// Quadrant correction of cos and sin, then the four coordinate products,
// each behind its own register. Depends on rpay_pkg.
module rpay_mult
    import rpay_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  pipe_ctl_t ctl,
    input  logic      in_valid,
    input  cord_t     in_data,
    output logic      out_valid,
    output prod_t     out_data
);

    logic  vec_valid_reg;
    vec_t  vec_reg;
    vec_t  vec_next;
    logic  prod_valid_reg;
    prod_t prod_reg;
    prod_t prod_next;

    // Negate cos and sin when the angle was folded by pi.
    always_comb begin
        vec_next.px = in_data.px;
        vec_next.pz = in_data.pz;
        if (in_data.flip) begin
            vec_next.cx = -in_data.cx;
            vec_next.sy = -in_data.sy;
        end else begin
            vec_next.cx = in_data.cx;
            vec_next.sy = in_data.sy;
        end
    end

    // Exact signed products.
    always_comb begin
        prod_next.p_xc = MW'(vec_reg.px) * MW'(vec_reg.cx);
        prod_next.p_zs = MW'(vec_reg.pz) * MW'(vec_reg.sy);
        prod_next.p_zc = MW'(vec_reg.pz) * MW'(vec_reg.cx);
        prod_next.p_xs = MW'(vec_reg.px) * MW'(vec_reg.sy);
    end

    // Valid bits of both stages.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vec_valid_reg  <= 1'b0;
            prod_valid_reg <= 1'b0;
        end else if (ctl.ce) begin
            vec_valid_reg  <= in_valid;
            prod_valid_reg <= vec_valid_reg;
        end
    end

    // Payload of both stages.
    always_ff @(posedge aclk) begin
        if (ctl.ce) begin
            vec_reg  <= vec_next;
            prod_reg <= prod_next;
        end
    end

    assign out_valid = prod_valid_reg;
    assign out_data  = prod_reg;

endmodule

FILE: hdl/rpay_obuf.sv
// Output stage: sums, rounds and saturates the products into the output
// register, with a one-item skid register behind it. Depends on rpay_pkg.
module rpay_obuf
    import rpay_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      in_valid,
    input  prod_t     in_data,
    output pipe_ctl_t ctl,
    output logic      m_valid,
    input  logic      m_ready,
    output out_item_t m_item
);

    logic      out_valid_reg;
    logic      out_valid_next;
    out_item_t out_data_reg;
    out_item_t out_data_next;
    logic      skid_valid_reg;
    logic      skid_valid_next;
    out_item_t skid_data_reg;
    out_item_t skid_data_next;
    out_item_t rounded;
    logic      take_tail;

    // The pipeline moves whenever the skid register is empty.
    assign ctl.ce    = !skid_valid_reg;
    assign take_tail = ctl.ce && in_valid;

    // Final sums with round half up and clamp.
    always_comb begin
        rounded.rot_x = round_sat(SW'(in_data.p_xc) - SW'(in_data.p_zs));
        rounded.rot_z = round_sat(SW'(in_data.p_zc) + SW'(in_data.p_xs));
    end

    // Output and skid steering.
    always_comb begin
        out_valid_next  = out_valid_reg;
        out_data_next   = out_data_reg;
        skid_valid_next = skid_valid_reg;
        skid_data_next  = skid_data_reg;
        if (out_valid_reg && !m_ready) begin
            if (take_tail) begin
                skid_valid_next = 1'b1;
                skid_data_next  = rounded;
            end
        end else if (skid_valid_reg) begin
            out_valid_next  = 1'b1;
            out_data_next   = skid_data_reg;
            skid_valid_next = 1'b0;
        end else begin
            out_valid_next = take_tail;
            out_data_next  = rounded;
        end
    end

    // Valid bits.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    // Payload.
    always_ff @(posedge aclk) begin
        out_data_reg  <= out_data_next;
        skid_data_reg <= skid_data_next;
    end

    assign m_valid = out_valid_reg;
    assign m_item  = out_data_reg;

endmodule

FILE: hdl/rpay_chk.sv
// Port-level checker for the y-axis point rotator, bound to the top level.
// Depends on rpay_pkg.
module rpay_chk
    import rpay_pkg::*;
(
    input logic      aclk,
    input logic      aresetn,
    input logic      s_ready,
    input logic      m_valid,
    input logic      m_ready,
    input out_item_t m_item
);

    // A result stays offered until it is taken.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid)
        else $error("result dropped before it was taken");

    // A stalled result keeps its payload.
    a_stable: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> $stable(m_item))
        else $error("result payload changed while stalled");

    // No result is offered right after reset.
    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result offered after reset");

    // Input stalls only because a stalled result has filled the skid register.
    a_stall_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        $fell(s_ready) |-> $past(m_valid && !m_ready))
        else $error("input stalled without a stalled result");

    // While the input is stalled a result is always on offer.
    a_stall_out: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> m_valid)
        else $error("input stalled with no result on offer");

endmodule

bind rotate_point_about_y_axis rpay_chk u_chk (.*);
